// ===== sv/ppc_pkg.sv =====
// Shared types and constants for the point plane classifier.
// No dependencies; every other file imports this package.
package ppc_pkg;

  // Default parameter values
  localparam int DEF_NOISE_SLOPE      = 983;
  localparam int DEF_COUNT_BITS       = 20;
  localparam int DEF_NORMAL_FRAC_BITS = 14;

  // Fixed datapath widths
  localparam int ACC_W      = 34;  // holds n.p + d*2^F for any F in range
  localparam int DIST_W     = 18;
  localparam int CNT_OUT_W  = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_MIN_Y    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_MARGIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_VALID    = 3'd7;

  // Configuration reset values
  localparam logic signed [15:0] RST_NORMAL_X       = 16'sd0;
  localparam logic signed [15:0] RST_NORMAL_Y       = -16'sd16384;
  localparam logic signed [15:0] RST_NORMAL_Z       = 16'sd0;
  localparam logic signed [15:0] RST_PLANE_OFFSET   = 16'sd0;
  localparam logic [9:0]         RST_TOLERANCE      = 10'd30;
  localparam logic signed [15:0] RST_FLOOR_MIN_Y    = 16'sd1000;
  localparam logic [14:0]        RST_CEILING_MARGIN = 15'd0;
  localparam logic               RST_PLANE_VALID    = 1'b0;

  typedef enum logic [1:0] {
    LBL_GROUND   = 2'd0,
    LBL_CEILING  = 2'd1,
    LBL_OBSTACLE = 2'd2
  } label_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] plane_offset;
    logic [9:0]         tolerance;
    logic signed [15:0] floor_min_y;
    logic [14:0]        ceiling_margin;
    logic               plane_valid;
  } cfg_t;

  // Classified point handed from front to back
  typedef struct packed {
    label_t                    label;
    logic signed [DIST_W-1:0]  dist_mm;
    logic                      floor_cand;
    logic                      inlier;
    logic                      frame_end;
  } rec_t;

endpackage

// ===== sv/ppc_front.sv =====
// Front pipeline: accepts points, computes plane distance, label and inlier test.
// Depends on ppc_pkg; feeds ppc_queue.
module ppc_front #(
  parameter int NOISE_SLOPE      = ppc_pkg::DEF_NOISE_SLOPE,
  parameter int NORMAL_FRAC_BITS = ppc_pkg::DEF_NORMAL_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ppc_pkg::cfg_t      cfg,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic               frame_end,
  output logic               rec_vld,
  output ppc_pkg::rec_t      rec,
  input  logic               q_full
);
  import ppc_pkg::*;

  localparam int SQ_W  = 2 * ACC_W;
  localparam int SHIFT = 32 - 2 * NORMAL_FRAC_BITS;
  localparam int CMP_W = SQ_W + SHIFT;
  localparam logic [63:0] SLOPE_SQ_FULL = 64'(NOISE_SLOPE) * 64'(NOISE_SLOPE);
  localparam logic [31:0] SLOPE_SQ = SLOPE_SQ_FULL[31:0];
  localparam logic [ACC_W:0] ROUND_HALF =
    {{ACC_W{1'b0}}, 1'b1} << (NORMAL_FRAC_BITS - 1);

  logic adv;

  // Stage 1: products and squares
  logic               s1_vld_r, s1_vld_nxt;
  logic signed [31:0] s1_px_r, s1_py_r, s1_pz_r;
  logic [31:0]        s1_sx_r, s1_sy_r, s1_sz_r;
  logic signed [15:0] s1_y_r;
  logic               s1_fend_r;

  // Stage 2: accumulated distance and squared range
  logic                    s2_vld_r;
  logic signed [ACC_W-1:0] s2_acc_r, s2_acc_nxt;
  logic [31:0]             s2_r2_r;
  logic signed [15:0]      s2_y_r;
  logic                    s2_fend_r;
  logic signed [ACC_W-1:0] off_ext;

  // Stage 3: squares for the range-scaled test, label and distance
  logic                    s3_vld_r;
  logic [SQ_W-1:0]         s3_sq_r, s3_sq_nxt;
  logic [63:0]             s3_rhs_r;
  label_t                  s3_label_r, s3_label_nxt;
  logic signed [DIST_W-1:0] s3_dist_r, s3_dist_nxt;
  logic                    s3_floor_r, s3_floor_nxt;
  logic                    s3_tol_r, s3_tol_nxt;
  logic                    s3_fend_r;

  logic signed [ACC_W-1:0] tolq;
  logic signed [ACC_W:0]   rnd;
  logic signed [ACC_W:0]   quo;
  logic [ACC_W-DIST_W+1:0] quo_hi;
  logic signed [16:0]      y_ext;
  logic signed [16:0]      neg_margin;
  logic [CMP_W-1:0]        cmp_lhs;
  logic [CMP_W-1:0]        cmp_rhs;

  // Stall the whole pipe only when the last stage cannot hand off
  assign adv        = !(s3_vld_r && q_full);
  assign full       = !adv;
  assign s1_vld_nxt = push && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r   <= cfg.normal_x * pos_x;
      s1_py_r   <= cfg.normal_y * pos_y;
      s1_pz_r   <= cfg.normal_z * pos_z;
      s1_sx_r   <= 32'(pos_x * pos_x);
      s1_sy_r   <= 32'(pos_y * pos_y);
      s1_sz_r   <= 32'(pos_z * pos_z);
      s1_y_r    <= pos_y;
      s1_fend_r <= frame_end;
    end
  end

  // Stage 2: sum the dot product with the scaled offset
  always_comb begin
    off_ext    = ACC_W'(cfg.plane_offset);
    s2_acc_nxt = ACC_W'(s1_px_r) + ACC_W'(s1_py_r) + ACC_W'(s1_pz_r)
               + (off_ext <<< NORMAL_FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_acc_r  <= s2_acc_nxt;
      s2_r2_r   <= s1_sx_r + s1_sy_r + s1_sz_r;
      s2_y_r    <= s1_y_r;
      s2_fend_r <= s1_fend_r;
    end
  end

  // Stage 3: round and saturate distance, classify
  always_comb begin
    tolq       = ACC_W'(cfg.tolerance) <<< NORMAL_FRAC_BITS;
    rnd        = (ACC_W + 1)'(s2_acc_r) + $signed(ROUND_HALF);
    quo        = rnd >>> NORMAL_FRAC_BITS;
    quo_hi     = quo[ACC_W:DIST_W-1];
    if (quo_hi == '0 || quo_hi == '1) begin
      s3_dist_nxt = quo[DIST_W-1:0];
    end else if (quo[ACC_W]) begin
      s3_dist_nxt = {1'b1, {(DIST_W-1){1'b0}}};
    end else begin
      s3_dist_nxt = {1'b0, {(DIST_W-1){1'b1}}};
    end

    y_ext      = 17'(s2_y_r);
    neg_margin = 17'sd0 - $signed({2'b00, cfg.ceiling_margin});
    // Below the plane or within tolerance means acc under tolq
    if (cfg.plane_valid && (s2_acc_r < tolq)) begin
      s3_label_nxt = LBL_GROUND;
    end else if (y_ext < neg_margin) begin
      s3_label_nxt = LBL_CEILING;
    end else begin
      s3_label_nxt = LBL_OBSTACLE;
    end

    s3_floor_nxt = (s2_y_r >= cfg.floor_min_y);
    s3_tol_nxt   = (s2_acc_r < tolq) && (s2_acc_r > -tolq);
    s3_sq_nxt    = SQ_W'(s2_acc_r) * SQ_W'(s2_acc_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sq_r    <= s3_sq_nxt;
      s3_rhs_r   <= 64'(SLOPE_SQ) * 64'(s2_r2_r);
      s3_label_r <= s3_label_nxt;
      s3_dist_r  <= s3_dist_nxt;
      s3_floor_r <= s3_floor_nxt;
      s3_tol_r   <= s3_tol_nxt;
      s3_fend_r  <= s2_fend_r;
    end
  end

  // Compare squared distance against squared range-scaled slope
  always_comb begin
    cmp_lhs        = CMP_W'(s3_sq_r) << SHIFT;
    cmp_rhs        = CMP_W'(s3_rhs_r);
    rec.label      = s3_label_r;
    rec.dist_mm    = s3_dist_r;
    rec.floor_cand = s3_floor_r;
    rec.inlier     = s3_floor_r && (s3_tol_r || (cmp_lhs < cmp_rhs));
    rec.frame_end  = s3_fend_r;
  end

  assign rec_vld = s3_vld_r;

endmodule

// ===== sv/ppc_queue.sv =====
// Short queue of classified points between front and back.
// Depends on ppc_pkg.
module ppc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  ppc_pkg::rec_t wr_rec,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_vld,
  output ppc_pkg::rec_t rd_rec
);
  import ppc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  rec_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   fill_r, fill_nxt;
  logic             do_wr, do_rd;

  assign full   = (fill_r == (PTR_W + 1)'(QUEUE_DEPTH));
  assign rd_vld = (fill_r != '0);
  assign rd_rec = slot_r[rd_ptr_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && rd_vld;

  // Advance pointers and track fill level
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (PTR_W + 1)'(do_wr) - (PTR_W + 1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

// ===== sv/ppc_back.sv =====
// Back end: updates per-frame counters and holds the result register.
// Depends on ppc_pkg; drains ppc_queue.
module ppc_back #(
  parameter int COUNT_BITS = ppc_pkg::DEF_COUNT_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_vld,
  input  ppc_pkg::rec_t                       q_rec,
  output logic                                q_pop,
  output logic                                empty,
  input  logic                                pop,
  output logic [1:0]                          label,
  output logic signed [ppc_pkg::DIST_W-1:0]   dist_mm,
  output logic [ppc_pkg::CNT_OUT_W-1:0]       floor_count,
  output logic [ppc_pkg::CNT_OUT_W-1:0]       inlier_count,
  output logic                                frame_done
);
  import ppc_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic                     out_vld_r, out_vld_nxt;
  logic                     take;
  logic [COUNT_BITS-1:0]    floor_cnt_r, floor_cnt_nxt, floor_new;
  logic [COUNT_BITS-1:0]    inlier_cnt_r, inlier_cnt_nxt, inlier_new;
  logic [COUNT_BITS+CNT_OUT_W-1:0] floor_wide, inlier_wide;
  label_t                   label_r;
  logic signed [DIST_W-1:0] dist_r;
  logic [CNT_OUT_W-1:0]     floor_out_r, inlier_out_r;
  logic                     fdone_r;

  // Load the result register when it is free or being drained
  assign take        = q_vld && (!out_vld_r || pop);
  assign q_pop       = take;
  assign out_vld_nxt = take || (out_vld_r && !pop);

  // Saturating bump, then clear after the last point of a frame
  always_comb begin
    floor_new  = floor_cnt_r;
    inlier_new = inlier_cnt_r;
    if (q_rec.floor_cand && floor_cnt_r != CNT_MAX) begin
      floor_new = floor_cnt_r + 1'b1;
    end
    if (q_rec.inlier && inlier_cnt_r != CNT_MAX) begin
      inlier_new = inlier_cnt_r + 1'b1;
    end
    floor_cnt_nxt  = q_rec.frame_end ? '0 : floor_new;
    inlier_cnt_nxt = q_rec.frame_end ? '0 : inlier_new;
    floor_wide     = {{CNT_OUT_W{1'b0}}, floor_new};
    inlier_wide    = {{CNT_OUT_W{1'b0}}, inlier_new};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r    <= 1'b0;
      floor_cnt_r  <= '0;
      inlier_cnt_r <= '0;
    end else begin
      out_vld_r <= out_vld_nxt;
      if (take) begin
        floor_cnt_r  <= floor_cnt_nxt;
        inlier_cnt_r <= inlier_cnt_nxt;
      end
    end
  end

  // Hold the result beat until popped
  always_ff @(posedge clk) begin
    if (take) begin
      label_r      <= q_rec.label;
      dist_r       <= q_rec.dist_mm;
      floor_out_r  <= floor_wide[CNT_OUT_W-1:0];
      inlier_out_r <= inlier_wide[CNT_OUT_W-1:0];
      fdone_r      <= q_rec.frame_end;
    end
  end

  assign empty        = !out_vld_r;
  assign label        = label_r;
  assign dist_mm      = dist_r;
  assign floor_count  = floor_out_r;
  assign inlier_count = inlier_out_r;
  assign frame_done   = fdone_r;

endmodule

// ===== sv/point_plane_classifier_unit.sv =====
// Point plane classifier: one point per cycle sustained while results are popped;
// otherwise full stalls the input. A result passes through two more front stages,
// one queue slot, then the result register. The front multipliers and the queue
// set that pipeline depth.
// Reset (synchronous, rst_n low) empties the pipe, clears the frame counters
// and loads the configuration registers with their defaults.
// Depends on ppc_pkg, ppc_front, ppc_queue and ppc_back.
module point_plane_classifier_unit #(
  parameter int NOISE_SLOPE      = ppc_pkg::DEF_NOISE_SLOPE,
  parameter int COUNT_BITS       = ppc_pkg::DEF_COUNT_BITS,
  parameter int NORMAL_FRAC_BITS = ppc_pkg::DEF_NORMAL_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic signed [15:0]                 in_pos_x,
  input  logic signed [15:0]                 in_pos_y,
  input  logic signed [15:0]                 in_pos_z,
  input  logic                               in_frame_end,
  output logic                               empty,
  input  logic                               pop,
  output logic [1:0]                         out_label,
  output logic signed [ppc_pkg::DIST_W-1:0]  out_dist_mm,
  output logic [ppc_pkg::CNT_OUT_W-1:0]      out_floor_count,
  output logic [ppc_pkg::CNT_OUT_W-1:0]      out_inlier_count,
  output logic                               out_frame_done,
  input  logic                               cfg_we,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ppc_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic rec_vld, q_full, q_vld, q_pop;
  rec_t front_rec, q_rec;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_X:       cfg_nxt.normal_x       = cfg_wdata;
        REG_NORMAL_Y:       cfg_nxt.normal_y       = cfg_wdata;
        REG_NORMAL_Z:       cfg_nxt.normal_z       = cfg_wdata;
        REG_PLANE_OFFSET:   cfg_nxt.plane_offset   = cfg_wdata;
        REG_TOLERANCE:      cfg_nxt.tolerance      = cfg_wdata[9:0];
        REG_FLOOR_MIN_Y:    cfg_nxt.floor_min_y    = cfg_wdata;
        REG_CEILING_MARGIN: cfg_nxt.ceiling_margin = cfg_wdata[14:0];
        REG_PLANE_VALID:    cfg_nxt.plane_valid    = cfg_wdata[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_x       <= RST_NORMAL_X;
      cfg_r.normal_y       <= RST_NORMAL_Y;
      cfg_r.normal_z       <= RST_NORMAL_Z;
      cfg_r.plane_offset   <= RST_PLANE_OFFSET;
      cfg_r.tolerance      <= RST_TOLERANCE;
      cfg_r.floor_min_y    <= RST_FLOOR_MIN_Y;
      cfg_r.ceiling_margin <= RST_CEILING_MARGIN;
      cfg_r.plane_valid    <= RST_PLANE_VALID;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ppc_front #(
    .NOISE_SLOPE      (NOISE_SLOPE),
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .push      (push),
    .full      (full),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .pos_z     (in_pos_z),
    .frame_end (in_frame_end),
    .rec_vld   (rec_vld),
    .rec       (front_rec),
    .q_full    (q_full)
  );

  ppc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (rec_vld),
    .wr_rec (front_rec),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_vld (q_vld),
    .rd_rec (q_rec)
  );

  ppc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_vld        (q_vld),
    .q_rec        (q_rec),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .label        (out_label),
    .dist_mm      (out_dist_mm),
    .floor_count  (out_floor_count),
    .inlier_count (out_inlier_count),
    .frame_done   (out_frame_done)
  );

endmodule
